// File: rtl/mvsu_pkg.sv
// ----------------------------------------------------------------------------
// mvsu_pkg
// Types, register codes, reset values and helper functions for the voxel
// source update pipeline.
// ----------------------------------------------------------------------------
package mvsu_pkg;

    typedef struct packed {
        logic signed [15:0] prolif_in;
        logic signed [15:0] infil_in;
        logic signed [15:0] necro_in;
        logic signed [15:0] oxygen_in;
        logic signed [15:0] grey_in;
        logic signed [15:0] white_in;
        logic signed [15:0] diffusion_term;
        logic        [15:0] growth_coef;
        logic               last_in;
    } t_vox_in;

    typedef struct packed {
        logic signed [15:0] prolif_out;
        logic signed [15:0] infil_out;
        logic signed [15:0] necro_out;
        logic        [14:0] oxygen_out;
        logic signed [15:0] grey_out;
        logic signed [15:0] white_out;
        logic               last_out;
    } t_vox_out;

    typedef enum logic [2:0] {
        CFG_TIME_STEP       = 3'd0,
        CFG_HYPOXIA_LEVEL   = 3'd1,
        CFG_INVASION_LEVEL  = 3'd2,
        CFG_TRANSITION_RATE = 3'd3,
        CFG_RETURN_RATE     = 3'd4,
        CFG_DEATH_RATE      = 3'd5,
        CFG_OXYGEN_SUPPLY   = 3'd6,
        CFG_OXYGEN_USE      = 3'd7
    } t_cfg_idx;

    localparam logic [15:0] RST_TIME_STEP       = 16'd655;
    localparam logic [14:0] RST_HYPOXIA_LEVEL   = 15'd11469;
    localparam logic [14:0] RST_INVASION_LEVEL  = 15'd11469;
    localparam logic [15:0] RST_TRANSITION_RATE = 16'd409;
    localparam logic [15:0] RST_RETURN_RATE     = 16'd409;
    localparam logic [15:0] RST_DEATH_RATE      = 16'd4096;
    localparam logic [15:0] RST_OXYGEN_SUPPLY   = 16'd4096;
    localparam logic [15:0] RST_OXYGEN_USE      = 16'd4096;

    localparam logic signed [15:0] HEALTHY_MIN = 16'sd163;
    localparam longint unsigned    Q30_ONE     = 64'd1 << 30;

    // quotient bits and latency of the fraction divider
    localparam int DIV_QB  = 16;
    localparam int DIV_LAT = DIV_QB + 2;

    typedef struct packed {
        logic signed [15:0] p;
        logic signed [15:0] i;
        logic signed [15:0] n;
        logic signed [15:0] ox;
        logic signed [15:0] g;
        logic signed [15:0] w;
        logic signed [15:0] dif;
        logic        [15:0] rho;
        logic               last;
    } t_pass;

    typedef struct packed {
        logic signed [39:0] big_g;
        logic signed [39:0] hg;
        logic signed [39:0] hw;
        logic signed [15:0] g;
        logic signed [15:0] w;
        logic signed [15:0] p_new;
        logic signed [15:0] i_new;
        logic signed [15:0] n_new;
        logic        [14:0] ox_new;
        logic               last;
    } t_hold;

    typedef struct packed {
        logic neg;
        logic zero;
        logic ovf;
    } t_div_ctl;

    // exp(-u) in Q30: fifth-order series of exp(-u/64), then squared six times
    function automatic longint unsigned exp_q30(input longint unsigned u);
        longint unsigned v;
        longint unsigned t;
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned e;
        v   = u >> 6;
        t   = Q30_ONE;
        pos = Q30_ONE;
        neg = 0;
        t   = (t * v) >> 30;
        neg = neg + t;
        t   = ((t * v) >> 30) / 2;
        pos = pos + t;
        t   = ((t * v) >> 30) / 3;
        neg = neg + t;
        t   = ((t * v) >> 30) / 4;
        pos = pos + t;
        t   = ((t * v) >> 30) / 5;
        neg = neg + t;
        e   = pos - neg;
        for (int k = 0; k < 6; k++) begin
            e = (e * e) >> 30;
        end
        return e;
    endfunction

    // clamp to +-0.125 and offset to 0..4095
    function automatic logic [11:0] clamp_off(input logic signed [17:0] d);
        logic [11:0] r;
        if (d < -18'sd2048) begin
            r = 12'd0;
        end else if (d > 18'sd2047) begin
            r = 12'hFFF;
        end else begin
            r = {~d[11], d[10:0]};
        end
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        logic signed [15:0] r;
        if (v > 32'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -32'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic [14:0] clamp_ox(input logic signed [31:0] v);
        logic [14:0] r;
        if (v < 32'sd0) begin
            r = 15'd0;
        end else if (v > 32'sd32767) begin
            r = 15'h7FFF;
        end else begin
            r = v[14:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/mvsu_div.sv
// ----------------------------------------------------------------------------
// mvsu_div
// Pipelined restoring divider for the healthy-tissue fraction
// num*16384/den, truncated toward zero and saturated to 16 bits.
// ----------------------------------------------------------------------------
module mvsu_div import mvsu_pkg::*; (
    input  logic               i_clk,
    input  logic signed [15:0] i_num,
    input  logic signed [16:0] i_den,
    input  logic               i_en,
    output logic signed [15:0] o_frac
);

    logic [29:0]       r_rem [0:DIV_QB];
    logic [16:0]       r_dv  [0:DIV_QB];
    logic [DIV_QB-1:0] r_q   [0:DIV_QB];
    t_div_ctl          r_ctl [0:DIV_QB];

    logic [15:0] w_anum;
    logic [16:0] w_aden;
    t_div_ctl    n_ctl;

    assign w_anum = i_num[15] ? 16'(-i_num) : 16'(i_num);
    assign w_aden = i_den[16] ? 17'(-i_den) : 17'(i_den);

    always_comb begin
        n_ctl.neg  = i_num[15] ^ i_den[16];
        n_ctl.zero = !i_en || (i_den == 17'sd0) || (i_num == 16'sd0);
        n_ctl.ovf  = {2'b00, w_anum} >= {w_aden, 1'b0, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= {w_anum, 14'd0};
        r_dv[0]  <= w_aden;
        r_q[0]   <= '0;
        r_ctl[0] <= n_ctl;
    end

    for (genvar s = 0; s < DIV_QB; s++) begin : g_step
        localparam int SH = DIV_QB - 1 - s;
        logic [32:0]       w_sub;
        logic [DIV_QB-1:0] n_q;

        assign w_sub = {3'b000, r_rem[s]} - ({16'd0, r_dv[s]} << SH);

        always_comb begin
            n_q     = r_q[s];
            n_q[SH] = !w_sub[32];
        end

        always_ff @(posedge i_clk) begin
            r_rem[s+1] <= w_sub[32] ? r_rem[s] : w_sub[29:0];
            r_dv[s+1]  <= r_dv[s];
            r_q[s+1]   <= n_q;
            r_ctl[s+1] <= r_ctl[s];
        end
    end

    logic w_big;
    assign w_big = r_ctl[DIV_QB].ovf || r_q[DIV_QB][DIV_QB-1];

    always_ff @(posedge i_clk) begin
        if (r_ctl[DIV_QB].zero) begin
            o_frac <= 16'sd0;
        end else if (r_ctl[DIV_QB].neg) begin
            o_frac <= w_big ? 16'sh8000 : 16'(-$signed({1'b0, r_q[DIV_QB]}));
        end else begin
            o_frac <= w_big ? 16'sh7FFF : $signed(r_q[DIV_QB]);
        end
    end

endmodule

// File: rtl/multispecies_voxel_source_update.sv
// ----------------------------------------------------------------------------
// multispecies_voxel_source_update
// Explicit Euler source update of one voxel's tumor, oxygen and tissue
// fractions, one voxel per clock.
//
// A voxel is taken on i_voxel at each clock edge with start high; busy is
// always low, so a voxel may be offered in every cycle. The updated voxel
// appears on o_result with o_done high for exactly one cycle, in input
// order. Throughput is one voxel per cycle; each voxel passes the 16-stage
// fraction divider plus the rate and time-step multiplier stages around it.
// The eight rate registers are written through i_cfg_we / i_cfg_idx /
// i_cfg_wdata, one register per edge; the user must write them only while
// no voxel is in flight, as the block itself does not enforce it.
// Synchronous active-low reset clears all in-flight voxels and loads the
// default rates; results are never held back, the receiver takes each
// result in the cycle it is shown.
// ----------------------------------------------------------------------------
module multispecies_voxel_source_update import mvsu_pkg::*; #(
    parameter int SIGMOID_ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_vox_in     i_voxel,
    output logic        o_done,
    output t_vox_out    o_result,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);

    localparam int IDX_W = (SIGMOID_ENTRIES > 1) ? $clog2(SIGMOID_ENTRIES) : 1;
    localparam int DLY   = DIV_LAT - 8;
    localparam int NSTG  = DIV_LAT + 4;

    // configuration
    logic [15:0] r_time_step, r_transition_rate, r_return_rate;
    logic [15:0] r_death_rate, r_oxygen_supply, r_oxygen_use;
    logic [14:0] r_hypoxia_level, r_invasion_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step       <= RST_TIME_STEP;
            r_hypoxia_level   <= RST_HYPOXIA_LEVEL;
            r_invasion_level  <= RST_INVASION_LEVEL;
            r_transition_rate <= RST_TRANSITION_RATE;
            r_return_rate     <= RST_RETURN_RATE;
            r_death_rate      <= RST_DEATH_RATE;
            r_oxygen_supply   <= RST_OXYGEN_SUPPLY;
            r_oxygen_use      <= RST_OXYGEN_USE;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TIME_STEP:       r_time_step       <= i_cfg_wdata;
                CFG_HYPOXIA_LEVEL:   r_hypoxia_level   <= i_cfg_wdata[14:0];
                CFG_INVASION_LEVEL:  r_invasion_level  <= i_cfg_wdata[14:0];
                CFG_TRANSITION_RATE: r_transition_rate <= i_cfg_wdata;
                CFG_RETURN_RATE:     r_return_rate     <= i_cfg_wdata;
                CFG_DEATH_RATE:      r_death_rate      <= i_cfg_wdata;
                CFG_OXYGEN_SUPPLY:   r_oxygen_supply   <= i_cfg_wdata;
                CFG_OXYGEN_USE:      r_oxygen_use      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // sigmoid table
    logic [14:0] w_sig_tbl [SIGMOID_ENTRIES];

    for (genvar k = 0; k < SIGMOID_ENTRIES; k++) begin : g_sig
        localparam longint C = 2 * k + 1 - SIGMOID_ENTRIES;
        localparam longint unsigned A = (C < 0) ? -C : C;
        localparam longint unsigned U = ((64'd25 * A) << 30) / (2 * SIGMOID_ENTRIES);
        localparam longint unsigned E = exp_q30(U);
        localparam longint unsigned DEN = Q30_ONE + E;
        localparam longint unsigned NUM = (C >= 0) ? Q30_ONE : E;
        localparam logic [14:0] ENT = 15'(((NUM << 14) + DEN / 2) / DEN);
        assign w_sig_tbl[k] = ENT;
    end

    // valid bits
    logic            w_acc;
    logic [NSTG-1:0] r_vld;

    assign busy  = 1'b0;
    assign w_acc = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NSTG-2:0], w_acc};
        end
    end

    // stage 1: oxygen offsets and first products
    t_pass              w_in;
    logic signed [17:0] w_dh, w_dv, w_sum4;
    logic signed [16:0] w_cp, w_ci, w_cox, w_sgw;
    logic [11:0]        w_offh, w_offv;
    logic [24:0]        w_prh, w_prv;

    always_comb begin
        w_in.p    = i_voxel.prolif_in;
        w_in.i    = i_voxel.infil_in;
        w_in.n    = i_voxel.necro_in;
        w_in.ox   = i_voxel.oxygen_in;
        w_in.g    = i_voxel.grey_in;
        w_in.w    = i_voxel.white_in;
        w_in.dif  = i_voxel.diffusion_term;
        w_in.rho  = i_voxel.growth_coef;
        w_in.last = i_voxel.last_in;
    end

    assign w_dh   = w_in.ox - $signed({3'b000, r_hypoxia_level});
    assign w_dv   = w_in.ox - $signed({3'b000, r_invasion_level});
    assign w_offh = clamp_off(w_dh);
    assign w_offv = clamp_off(w_dv);
    assign w_prh  = 25'(w_offh) * 25'(SIGMOID_ENTRIES);
    assign w_prv  = 25'(w_offv) * 25'(SIGMOID_ENTRIES);
    assign w_cp   = 17'sd16384 - w_in.p;
    assign w_ci   = 17'sd16384 - w_in.i;
    assign w_cox  = 17'sd16384 - w_in.ox;
    assign w_sum4 = w_in.p + w_in.i + w_in.g + w_in.w;
    assign w_sgw  = w_in.g + w_in.w;

    logic [IDX_W-1:0]   r1_idx_h, r1_idx_v;
    logic signed [32:0] r1_lp_raw, r1_li_raw, r1_beta_raw;
    logic signed [33:0] r1_sup_raw;
    logic signed [34:0] r1_use4p;
    logic signed [17:0] r1_sum4;
    logic signed [16:0] r1_sgw;
    t_pass              r1_pass;

    always_ff @(posedge i_clk) begin
        r1_idx_h    <= w_prh[12 +: IDX_W];
        r1_idx_v    <= w_prv[12 +: IDX_W];
        r1_lp_raw   <= w_in.p * w_cp;
        r1_li_raw   <= w_in.i * w_ci;
        r1_beta_raw <= $signed({1'b0, r_return_rate}) * w_in.ox;
        r1_sup_raw  <= $signed({1'b0, r_oxygen_supply}) * w_cox;
        r1_use4p    <= $signed({1'b0, r_oxygen_use}) * w_in.p * 35'sd4;
        r1_sum4     <= w_sum4;
        r1_sgw      <= w_sgw;
        r1_pass     <= w_in;
    end

    // fraction divider, runs alongside stages 1 to 18
    logic signed [15:0] w_f1, w_f2;
    logic               w_healthy;

    assign w_healthy = (w_in.g > HEALTHY_MIN) || (w_in.w > HEALTHY_MIN);

    mvsu_div u_div_g (
        .i_clk  (i_clk),
        .i_num  (w_in.g),
        .i_den  (w_sgw),
        .i_en   (w_healthy),
        .o_frac (w_f1)
    );

    mvsu_div u_div_w (
        .i_clk  (i_clk),
        .i_num  (w_in.w),
        .i_den  (w_sgw),
        .i_en   (w_healthy),
        .o_frac (w_f2)
    );

    // stage 2: table read and rounding
    logic signed [32:0] w_lp_t, w_li_t, w_beta_t;
    logic signed [33:0] w_sup_t;

    assign w_lp_t   = r1_lp_raw + 33'sd8192;
    assign w_li_t   = r1_li_raw + 33'sd8192;
    assign w_beta_t = r1_beta_raw + 33'sd2048;
    assign w_sup_t  = r1_sup_raw + 34'sd2048;

    logic [14:0]        r2_shyp, r2_sinv;
    logic signed [17:0] r2_lp, r2_li;
    logic signed [20:0] r2_beta;
    logic signed [21:0] r2_sup;
    logic signed [34:0] r2_use4p;
    logic signed [17:0] r2_sum4;
    logic signed [16:0] r2_sgw;
    t_pass              r2_pass;

    always_ff @(posedge i_clk) begin
        r2_shyp  <= w_sig_tbl[r1_idx_h];
        r2_sinv  <= w_sig_tbl[r1_idx_v];
        r2_lp    <= w_lp_t[31:14];
        r2_li    <= w_li_t[31:14];
        r2_beta  <= w_beta_t[32:12];
        r2_sup   <= w_sup_t[33:12];
        r2_use4p <= r1_use4p;
        r2_sum4  <= r1_sum4;
        r2_sgw   <= r1_sgw;
        r2_pass  <= r1_pass;
    end

    // stage 3: rate products
    logic [30:0]        r3_m_raw, r3_a_raw, r3_h_raw;
    logic signed [17:0] r3_lp, r3_li;
    logic signed [20:0] r3_beta;
    logic signed [21:0] r3_sup;
    logic signed [34:0] r3_use4p;
    logic signed [17:0] r3_sum4;
    logic signed [16:0] r3_sgw;
    t_pass              r3_pass;

    always_ff @(posedge i_clk) begin
        r3_m_raw <= r2_pass.rho * r2_shyp;
        r3_a_raw <= r_transition_rate * (15'd16384 - r2_sinv);
        r3_h_raw <= r_death_rate * (15'd16384 - r2_shyp);
        r3_lp    <= r2_lp;
        r3_li    <= r2_li;
        r3_beta  <= r2_beta;
        r3_sup   <= r2_sup;
        r3_use4p <= r2_use4p;
        r3_sum4  <= r2_sum4;
        r3_sgw   <= r2_sgw;
        r3_pass  <= r2_pass;
    end

    // stage 4: rounding of m, alpha and death term
    logic [30:0] w_m_t, w_a_t, w_h_t;

    assign w_m_t = r3_m_raw + 31'd2048;
    assign w_a_t = r3_a_raw + 31'd2048;
    assign w_h_t = r3_h_raw + 31'd2048;

    logic [18:0]        r4_m, r4_alpha, r4_hd;
    logic signed [17:0] r4_lp, r4_li;
    logic signed [20:0] r4_beta;
    logic signed [21:0] r4_sup;
    logic signed [34:0] r4_use4p;
    logic signed [17:0] r4_sum4;
    logic signed [16:0] r4_sgw;
    t_pass              r4_pass;

    always_ff @(posedge i_clk) begin
        r4_m     <= w_m_t[30:12];
        r4_alpha <= w_a_t[30:12];
        r4_hd    <= w_h_t[30:12];
        r4_lp    <= r3_lp;
        r4_li    <= r3_li;
        r4_beta  <= r3_beta;
        r4_sup   <= r3_sup;
        r4_use4p <= r3_use4p;
        r4_sum4  <= r3_sum4;
        r4_sgw   <= r3_sgw;
        r4_pass  <= r3_pass;
    end

    // stage 5: term products
    logic signed [19:0] w_ms, w_as, w_hs;

    assign w_ms = $signed({1'b0, r4_m});
    assign w_as = $signed({1'b0, r4_alpha});
    assign w_hs = $signed({1'b0, r4_hd});

    logic signed [39:0] r5_gp, r5_gi, r5_ap, r5_bi, r5_hp, r5_hi;
    logic signed [39:0] r5_hn, r5_hg, r5_hw, r5_so;
    logic signed [34:0] r5_use4p;
    t_pass              r5_pass;

    always_ff @(posedge i_clk) begin
        r5_gp    <= w_ms * r4_lp;
        r5_gi    <= w_ms * r4_li;
        r5_ap    <= w_as * r4_pass.p;
        r5_bi    <= r4_beta * r4_pass.i;
        r5_hp    <= w_hs * r4_pass.p;
        r5_hi    <= w_hs * r4_pass.i;
        r5_hn    <= w_hs * r4_sum4;
        r5_hg    <= w_hs * r4_pass.g;
        r5_hw    <= w_hs * r4_pass.w;
        r5_so    <= r4_sup * r4_sgw;
        r5_use4p <= r4_use4p;
        r5_pass  <= r4_pass;
    end

    // stage 6: rate sums
    logic signed [39:0] w_dif_q;

    assign w_dif_q = $signed({{10{r5_pass.dif[15]}}, r5_pass.dif, 14'd0});

    logic signed [39:0] r6_rp, r6_ri, r6_rn, r6_ro, r6_bigg, r6_hg, r6_hw;
    t_pass              r6_pass;

    always_ff @(posedge i_clk) begin
        r6_rp   <= r5_gp - r5_ap + r5_bi - r5_hp;
        r6_ri   <= r5_gi + r5_ap - r5_bi - r5_hi;
        r6_rn   <= r5_hn;
        r6_ro   <= r5_so - r5_use4p;
        r6_bigg <= r5_gp + r5_gi + w_dif_q;
        r6_hg   <= r5_hg;
        r6_hw   <= r5_hw;
        r6_pass <= r5_pass;
    end

    // stage 7: time-step products
    logic signed [16:0] w_dt;

    assign w_dt = $signed({1'b0, r_time_step});

    logic signed [56:0] r7_xp, r7_xi, r7_xn, r7_xo;
    logic signed [39:0] r7_bigg, r7_hg, r7_hw;
    t_pass              r7_pass;

    always_ff @(posedge i_clk) begin
        r7_xp   <= r6_rp * w_dt;
        r7_xi   <= r6_ri * w_dt;
        r7_xn   <= r6_rn * w_dt;
        r7_xo   <= r6_ro * w_dt;
        r7_bigg <= r6_bigg;
        r7_hg   <= r6_hg;
        r7_hw   <= r6_hw;
        r7_pass <= r6_pass;
    end

    // stage 8: tumor and oxygen results
    logic signed [56:0] w_tp, w_ti, w_tn, w_to;
    logic signed [31:0] w_sp, w_si, w_sn, w_so;
    t_hold              n_hold;

    assign w_tp = r7_xp + 57'sd536870912;
    assign w_ti = r7_xi + 57'sd536870912;
    assign w_tn = r7_xn + 57'sd536870912;
    assign w_to = r7_xo + 57'sd536870912;
    assign w_sp = $signed(w_tp[56:30]) + r7_pass.p;
    assign w_si = $signed(w_ti[56:30]) + r7_pass.i;
    assign w_sn = $signed(w_tn[56:30]) + r7_pass.n;
    assign w_so = $signed(w_to[56:30]) + r7_pass.ox;

    always_comb begin
        n_hold.big_g  = r7_bigg;
        n_hold.hg     = r7_hg;
        n_hold.hw     = r7_hw;
        n_hold.g      = r7_pass.g;
        n_hold.w      = r7_pass.w;
        n_hold.p_new  = sat16(w_sp);
        n_hold.i_new  = sat16(w_si);
        n_hold.n_new  = sat16(w_sn);
        n_hold.ox_new = clamp_ox(w_so);
        n_hold.last   = r7_pass.last;
    end

    // delay line to meet the divider
    t_hold r_dly [0:DLY];

    always_ff @(posedge i_clk) begin
        r_dly[0] <= n_hold;
        for (int k = 1; k <= DLY; k++) begin
            r_dly[k] <= r_dly[k-1];
        end
    end

    // stage 19: tissue loss split by fraction
    logic signed [55:0] r19_fg, r19_fw;
    t_hold              r19_hold;

    always_ff @(posedge i_clk) begin
        r19_fg   <= w_f1 * r_dly[DLY].big_g;
        r19_fw   <= w_f2 * r_dly[DLY].big_g;
        r19_hold <= r_dly[DLY];
    end

    // stage 20: tissue rates
    logic signed [55:0] w_fg_t, w_fw_t;

    assign w_fg_t = r19_fg + 56'sd8192;
    assign w_fw_t = r19_fw + 56'sd8192;

    logic signed [43:0] r20_rg, r20_rw;
    t_hold              r20_hold;

    always_ff @(posedge i_clk) begin
        r20_rg   <= $signed(w_fg_t[55:14]) + r19_hold.hg;
        r20_rw   <= $signed(w_fw_t[55:14]) + r19_hold.hw;
        r20_hold <= r19_hold;
    end

    // stage 21: tissue time-step products
    logic signed [60:0] r21_xg, r21_xw;
    t_hold              r21_hold;

    always_ff @(posedge i_clk) begin
        r21_xg   <= r20_rg * w_dt;
        r21_xw   <= r20_rw * w_dt;
        r21_hold <= r20_hold;
    end

    // stage 22: output register
    logic signed [60:0] w_tg, w_tw;
    logic signed [31:0] w_sg, w_sw;

    assign w_tg = r21_xg + 61'sd536870912;
    assign w_tw = r21_xw + 61'sd536870912;
    assign w_sg = r21_hold.g - $signed(w_tg[60:30]);
    assign w_sw = r21_hold.w - $signed(w_tw[60:30]);

    t_vox_out r_out;

    always_ff @(posedge i_clk) begin
        r_out.prolif_out <= r21_hold.p_new;
        r_out.infil_out  <= r21_hold.i_new;
        r_out.necro_out  <= r21_hold.n_new;
        r_out.oxygen_out <= r21_hold.ox_new;
        r_out.grey_out   <= sat16(w_sg);
        r_out.white_out  <= sat16(w_sw);
        r_out.last_out   <= r21_hold.last;
    end

    assign o_result = r_out;
    assign o_done   = r_vld[NSTG-1];

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the voxel source update pipeline. A directed table
// of voxel extremes is walked first, then bursts of random voxels under
// several rate settings. Every output transfer is compared field by field
// against a typed row value or a behavioral Euler source update predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import mvsu_pkg::*;

    localparam int N_SIG      = 256;
    localparam int PIPE_DRAIN = 30;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_vox_in     i_voxel;
    logic        o_done;
    t_vox_out    o_result;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_wdata;

    multispecies_voxel_source_update #(.SIGMOID_ENTRIES(N_SIG)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_voxel    (i_voxel),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    typedef struct {
        t_vox_in  vox;
        bit       typed;
        t_vox_out want;
    } t_row;

    longint   rate_reg [8];
    longint   sig_tab  [N_SIG];
    t_vox_out pending_voxels [$];
    t_vox_out typed_want [$];
    bit       typed_flag [$];
    int       fail_cnt;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic longint sig_entry(int k);
        longint c;
        longint unsigned a, u, v, t, pos, neg, e, num, den;
        c = 2 * k + 1 - N_SIG;
        a = (c < 0) ? -c : c;
        u = ((64'd25 * a) << 30) / (2 * N_SIG);
        v = u >> 6;
        t = Q30_ONE;
        pos = Q30_ONE;
        neg = 0;
        for (int j = 1; j <= 5; j++) begin
            t = ((t * v) >> 30) / j;
            if (j % 2 == 1) neg += t; else pos += t;
        end
        e = pos - neg;
        for (int j = 0; j < 6; j++) e = (e * e) >> 30;
        den = Q30_ONE + e;
        num = (c >= 0) ? Q30_ONE : e;
        return longint'(((num << 14) + den / 2) / den);
    endfunction

    function automatic longint sig_lookup(longint d);
        if (d < -2048) d = -2048;
        if (d > 2047) d = 2047;
        return sig_tab[((d + 2048) * N_SIG) / 4096];
    endfunction

    function automatic longint round_up(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint share(longint a, longint s);
        if (s == 0) return 0;
        return clip16((a * 16384) / s);
    endfunction

    function automatic longint growth(longint x);
        return round_up(x * (16384 - x), 14);
    endfunction

    function automatic t_vox_out predict_update(t_vox_in x);
        longint p, i, n, ox, g, w, dif, rho, dt;
        longint s_hyp, s_inv, m, alpha, beta, hd, gp, gi;
        longint rp, ri, rn, ro, rg, rw, supply, f1, f2, big_g, onew;
        t_vox_out r;
        p   = x.prolif_in;
        i   = x.infil_in;
        n   = x.necro_in;
        ox  = x.oxygen_in;
        g   = x.grey_in;
        w   = x.white_in;
        dif = x.diffusion_term;
        rho = x.growth_coef;
        dt  = rate_reg[CFG_TIME_STEP];
        s_hyp = sig_lookup(ox - rate_reg[CFG_HYPOXIA_LEVEL]);
        s_inv = sig_lookup(ox - rate_reg[CFG_INVASION_LEVEL]);
        m     = round_up(rho * s_hyp, 12);
        alpha = round_up(rate_reg[CFG_TRANSITION_RATE] * (16384 - s_inv), 12);
        beta  = round_up(rate_reg[CFG_RETURN_RATE] * ox, 12);
        hd    = round_up(rate_reg[CFG_DEATH_RATE] * (16384 - s_hyp), 12);
        gp    = m * growth(p);
        gi    = m * growth(i);
        rp = gp - alpha * p + beta * i - hd * p;
        ri = gi + alpha * p - beta * i - hd * i;
        rn = hd * (p + i + g + w);
        supply = round_up(rate_reg[CFG_OXYGEN_SUPPLY] * (16384 - ox), 12);
        ro = -(rate_reg[CFG_OXYGEN_USE] * p * 4) + supply * (g + w);
        if (g > 163 || w > 163) begin
            f1 = share(g, g + w);
            f2 = share(w, g + w);
        end else begin
            f1 = 0;
            f2 = 0;
        end
        big_g = gp + gi + dif * 16384;
        rg = round_up(f1 * big_g, 14) + hd * g;
        rw = round_up(f2 * big_g, 14) + hd * w;
        onew = ox + round_up(ro * dt, 30);
        if (onew < 0) onew = 0;
        if (onew > 32767) onew = 32767;
        r.prolif_out = clip16(p + round_up(rp * dt, 30));
        r.infil_out  = clip16(i + round_up(ri * dt, 30));
        r.necro_out  = clip16(n + round_up(rn * dt, 30));
        r.oxygen_out = onew;
        r.grey_out   = clip16(g - round_up(rg * dt, 30));
        r.white_out  = clip16(w - round_up(rw * dt, 30));
        r.last_out   = x.last_in;
        return r;
    endfunction

    // input transfers: queue the prediction, or the typed value for typed table rows
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            if (typed_flag.size() > 0 && typed_flag[0]) begin
                pending_voxels.push_back(typed_want[0]);
            end else begin
                pending_voxels.push_back(predict_update(i_voxel));
            end
            if (typed_flag.size() > 0) begin
                void'(typed_flag.pop_front());
                void'(typed_want.pop_front());
            end
        end
    end

    // output transfers
    always @(posedge i_clk) begin
        t_vox_out e;
        if (i_rst_n && o_done) begin
            if (pending_voxels.size() == 0) begin
                $error("unexpected result transfer");
                fail_cnt++;
            end else begin
                e = pending_voxels.pop_front();
                if (o_result.prolif_out !== e.prolif_out) begin
                    $error("prolif_out exp %0d got %0d", e.prolif_out, o_result.prolif_out);
                    fail_cnt++;
                end
                if (o_result.infil_out !== e.infil_out) begin
                    $error("infil_out exp %0d got %0d", e.infil_out, o_result.infil_out);
                    fail_cnt++;
                end
                if (o_result.necro_out !== e.necro_out) begin
                    $error("necro_out exp %0d got %0d", e.necro_out, o_result.necro_out);
                    fail_cnt++;
                end
                if (o_result.oxygen_out !== e.oxygen_out) begin
                    $error("oxygen_out exp %0d got %0d", e.oxygen_out, o_result.oxygen_out);
                    fail_cnt++;
                end
                if (o_result.grey_out !== e.grey_out) begin
                    $error("grey_out exp %0d got %0d", e.grey_out, o_result.grey_out);
                    fail_cnt++;
                end
                if (o_result.white_out !== e.white_out) begin
                    $error("white_out exp %0d got %0d", e.white_out, o_result.white_out);
                    fail_cnt++;
                end
                if (o_result.last_out !== e.last_out) begin
                    $error("last_out exp %0d got %0d", e.last_out, o_result.last_out);
                    fail_cnt++;
                end
            end
        end
    end

    task automatic load_rates(input logic [15:0] v [8]);
        for (int k = 0; k < 8; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= k[2:0];
            i_cfg_wdata <= v[k];
            rate_reg[k] = (k == CFG_HYPOXIA_LEVEL || k == CFG_INVASION_LEVEL) ?
                          v[k] & 16'h7FFF : v[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain;
        while (pending_voxels.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    // one transfer; start stays high when the next voxel follows at once
    task automatic send_voxel(input t_vox_in x, input bit typed, input t_vox_out want);
        i_voxel <= x;
        start   <= 1'b1;
        typed_flag.push_back(typed);
        typed_want.push_back(want);
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
    endtask

    function automatic t_vox_in rand_voxel();
        t_vox_in x;
        x = {$urandom, $urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(0, 3))
            0: begin
                x.prolif_in = $urandom_range(0, 16384);
                x.infil_in  = $urandom_range(0, 16384);
                x.necro_in  = $urandom_range(0, 16384);
                x.grey_in   = $urandom_range(0, 16384);
                x.white_in  = $urandom_range(0, 16384);
                x.oxygen_in = rate_reg[CFG_HYPOXIA_LEVEL] + $urandom_range(0, 5000) - 2500;
                x.diffusion_term = $urandom_range(0, 2000) - 1000;
                x.growth_coef    = $urandom_range(0, 8192);
            end
            1: begin
                x.grey_in  = $urandom_range(0, 400) - 200;
                x.white_in = $urandom_range(0, 400) - 200;
            end
            default: ;
        endcase
        return x;
    endfunction

    task automatic random_bursts(input int count);
        int sent;
        t_vox_out nil;
        nil  = '0;
        sent = 0;
        while (sent < count) begin
            for (int b = $urandom_range(1, 12); b > 0 && sent < count; b--) begin
                send_voxel(rand_voxel(), 1'b0, nil);
                sent++;
            end
            if ($urandom_range(0, 3) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        start <= 1'b0;
    endtask

    t_row rows [$];

    initial begin
        logic [15:0] rv [8];
        t_row r;
        t_vox_out zero_out;
        fail_cnt    = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_voxel     = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_TIME_STEP;
        i_cfg_wdata = '0;
        for (int k = 0; k < N_SIG; k++) sig_tab[k] = sig_entry(k);
        rate_reg = '{655, 11469, 11469, 409, 409, 4096, 4096, 4096};
        zero_out = '0;

        // directed table
        r.vox = '0; r.typed = 1'b1; r.want = zero_out;
        rows.push_back(r);
        r.vox.last_in = 1'b1; r.want.last_out = 1'b1;
        rows.push_back(r);
        r.typed = 1'b0;
        r.vox = {16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                 16'sh7FFF, 16'hFFFF, 1'b1};
        rows.push_back(r);
        r.vox = {16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                 16'sh8000, 16'h0000, 1'b0};
        rows.push_back(r);
        r.vox = {16'sd8192, 16'sd4096, 16'sd0, 16'sd9421, 16'sd8000, 16'sd8000,
                 16'sd100, 16'd4096, 1'b0};
        rows.push_back(r);
        foreach (rows[j]) ;
        for (int d = -2049; d <= 2049; d += 683) begin
            r.vox.oxygen_in = 11469 + d;
            rows.push_back(r);
        end
        // healthy gate around 0.01
        r.vox.grey_in = 163; r.vox.white_in = 163; rows.push_back(r);
        r.vox.grey_in = 164; r.vox.white_in = 0;   rows.push_back(r);
        r.vox.grey_in = 0;   r.vox.white_in = 164; rows.push_back(r);
        // zero healthy sum, negative sum, oversized fraction
        r.vox.grey_in = 200;  r.vox.white_in = -200; rows.push_back(r);
        r.vox.grey_in = 300;  r.vox.white_in = -400; rows.push_back(r);
        r.vox.grey_in = 16384; r.vox.white_in = -16000; rows.push_back(r);
        r.vox = {16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh8000, 16'sh7FFF, 16'sh8000,
                 16'sh8000, 16'hFFFF, 1'b1};
        rows.push_back(r);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[j]) send_voxel(rows[j].vox, rows[j].typed, rows[j].want);
        random_bursts(250);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            for (int k = 0; k < 8; k++) begin
                case (ph)
                    0: rv[k] = 16'h0000;
                    1: rv[k] = (k == CFG_HYPOXIA_LEVEL || k == CFG_INVASION_LEVEL) ?
                               16'h7FFF : 16'hFFFF;
                    default: rv[k] = (k == CFG_HYPOXIA_LEVEL || k == CFG_INVASION_LEVEL) ?
                                     $urandom_range(0, 32767) : $urandom_range(0, 65535);
                endcase
            end
            if (ph == 0) rv[CFG_TIME_STEP] = 16'hFFFF;
            if (ph == 2) rv[CFG_TIME_STEP] = 16'h0000;
            load_rates(rv);
            random_bursts(130);
            drain();
        end

        if (fail_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #(20 * 200000);
        $display("TB_ERROR");
        $finish;
    end

endmodule

// File: filelist.f
rtl/mvsu_pkg.sv
rtl/mvsu_div.sv
rtl/multispecies_voxel_source_update.sv
bench/tb_top.sv
